FILE: rtl/lcdns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble sequencer package
// Shared types, register indexes and constants for the 4-bit character LCD
// sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Request codes carried in the kind field.
   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_COMMAND = 3'd1,
      KIND_DATA    = 3'd2,
      KIND_CURSOR  = 3'd3,
      KIND_CLEAR   = 3'd4,
      KIND_INIT    = 3'd5
   } kind_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_POWER_UP     = 3'd0,
      CSR_ENABLE       = 3'd1,
      CSR_BYTE_WAIT    = 3'd2,
      CSR_FUNCTION_SET = 3'd3,
      CSR_DISPLAY_CTRL = 3'd4,
      CSR_ENTRY_MODE   = 3'd5,
      CSR_LINE_BASE    = 3'd6
   } csr_index_type;

   // Sequencer stages.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_POWER,
      PH_NIB_EN,
      PH_NIB_LOW,
      PH_NIB_GAP,
      PH_HI_EN,
      PH_HI_LOW,
      PH_LO_EN,
      PH_LO_LOW,
      PH_WAIT
   } phase_type;

   typedef struct packed {
      logic [7:0] power_up_ticks;
      logic [3:0] enable_ticks;
      logic [3:0] byte_wait_ticks;
      logic [7:0] function_set_code;
      logic [7:0] display_control_code;
      logic [7:0] entry_mode_code;
      logic [6:0] second_line_base;
   } cfg_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] bus_nibble;
      logic       enable_pin;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] count;
      logic [7:0] byte_val;
      logic       rs;
      logic [3:0] nib;
      logic       en;
      logic       extra;
      logic [1:0] nib_idx;
      logic [2:0] cmd_idx;
   } seq_state_type;

   // Reset values of the configuration registers.
   localparam logic [7:0] RST_POWER_UP     = 8'd50;
   localparam logic [3:0] RST_ENABLE       = 4'd1;
   localparam logic [3:0] RST_BYTE_WAIT    = 4'd2;
   localparam logic [7:0] RST_FUNCTION_SET = 8'h28;
   localparam logic [7:0] RST_DISPLAY_CTRL = 8'h0C;
   localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;
   localparam logic [6:0] RST_LINE_BASE    = 7'h40;

   localparam logic [7:0] CLEAR_CODE     = 8'h01;
   localparam logic [7:0] CURSOR_FLAG    = 8'h80;
   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;
   localparam logic [7:0] GAP_LONG       = 8'd5;
   localparam logic [7:0] GAP_SHORT      = 8'd1;
   localparam logic [7:0] CLEAR_EXTRA    = 8'd2;
   localparam logic [1:0] NIB_LAST       = 2'd3;
   localparam logic [2:0] CMD_FUNCTION   = 3'd0;
   localparam logic [2:0] CMD_DISPLAY    = 3'd1;
   localparam logic [2:0] CMD_ENTRY      = 3'd2;
   localparam logic [2:0] CMD_LAST_INIT  = 3'd3;
   localparam logic [2:0] CMD_STANDALONE = 3'd4;

endpackage

FILE: rtl/lcdns_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble sequencer register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module lcdns_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lcdns_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lcdns_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lcdns_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output lcdns_pkg::cfg_type                cfg
);
   import lcdns_pkg::*;

   cfg_type     cfg_ff;
   logic        wr_en;
   logic [2:0]  index;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_up_ticks       <= RST_POWER_UP;
         cfg_ff.enable_ticks         <= RST_ENABLE;
         cfg_ff.byte_wait_ticks      <= RST_BYTE_WAIT;
         cfg_ff.function_set_code    <= RST_FUNCTION_SET;
         cfg_ff.display_control_code <= RST_DISPLAY_CTRL;
         cfg_ff.entry_mode_code      <= RST_ENTRY_MODE;
         cfg_ff.second_line_base     <= RST_LINE_BASE;
      end else if (wr_en) begin
         case (index)
            CSR_POWER_UP:     cfg_ff.power_up_ticks       <= csr_pwdata[7:0];
            CSR_ENABLE:       cfg_ff.enable_ticks         <= csr_pwdata[3:0];
            CSR_BYTE_WAIT:    cfg_ff.byte_wait_ticks      <= csr_pwdata[3:0];
            CSR_FUNCTION_SET: cfg_ff.function_set_code    <= csr_pwdata[7:0];
            CSR_DISPLAY_CTRL: cfg_ff.display_control_code <= csr_pwdata[7:0];
            CSR_ENTRY_MODE:   cfg_ff.entry_mode_code      <= csr_pwdata[7:0];
            CSR_LINE_BASE:    cfg_ff.second_line_base     <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (index)
         CSR_POWER_UP:     csr_prdata[7:0] = cfg_ff.power_up_ticks;
         CSR_ENABLE:       csr_prdata[3:0] = cfg_ff.enable_ticks;
         CSR_BYTE_WAIT:    csr_prdata[3:0] = cfg_ff.byte_wait_ticks;
         CSR_FUNCTION_SET: csr_prdata[7:0] = cfg_ff.function_set_code;
         CSR_DISPLAY_CTRL: csr_prdata[7:0] = cfg_ff.display_control_code;
         CSR_ENTRY_MODE:   csr_prdata[7:0] = cfg_ff.entry_mode_code;
         CSR_LINE_BASE:    csr_prdata[6:0] = cfg_ff.second_line_base;
         default:          csr_prdata      = '0;
      endcase
   end

endmodule

FILE: rtl/lcdns_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble sequencer core
// Holds the sequencer state and the pin levels, and moves one step per word.
// ----------------------------------------------------------------------------
module lcdns_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [2:0]         kind,
   input  logic [7:0]         byte_value,
   input  logic               line,
   input  logic [5:0]         column,
   input  lcdns_pkg::cfg_type cfg,
   output lcdns_pkg::rsp_type rsp
);
   import lcdns_pkg::*;

   seq_state_type st_ff;
   seq_state_type st_in;
   logic          busy;
   logic          is_request;

   function automatic logic [7:0] pulse_len(input cfg_type c);
      pulse_len = (c.enable_ticks == 4'd0) ? 8'd1 : {4'd0, c.enable_ticks};
   endfunction

   function automatic logic [7:0] init_code(input logic [2:0] k, input cfg_type c);
      logic [7:0] v;
      case (k)
         CMD_FUNCTION: v = c.function_set_code;
         CMD_DISPLAY:  v = c.display_control_code;
         CMD_ENTRY:    v = c.entry_mode_code;
         default:      v = CLEAR_CODE;
      endcase
      init_code = v;
   endfunction

   // Load the pin levels and the countdown for the stage held in s.phase.
   function automatic seq_state_type enter(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      logic [3:0]    wake;
      r       = s;
      r.count = 8'd0;
      wake    = (s.nib_idx == NIB_LAST) ? NIB_FOUR_BIT : NIB_WAKE;
      case (s.phase)
         PH_IDLE: begin
            r.en = 1'b0;
         end
         PH_POWER: begin
            r.rs    = 1'b0;
            r.en    = 1'b0;
            r.count = c.power_up_ticks;
         end
         PH_NIB_EN, PH_NIB_LOW: begin
            r.rs    = 1'b0;
            r.nib   = wake;
            r.en    = (s.phase == PH_NIB_EN);
            r.count = pulse_len(c);
         end
         PH_NIB_GAP: begin
            r.rs    = 1'b0;
            r.nib   = wake;
            r.en    = 1'b0;
            r.count = (s.nib_idx == NIB_LAST) ? GAP_SHORT : GAP_LONG;
         end
         PH_HI_EN: begin
            r.nib   = s.byte_val[7:4];
            r.en    = 1'b1;
            r.count = pulse_len(c);
         end
         PH_LO_EN: begin
            r.nib   = s.byte_val[3:0];
            r.en    = 1'b1;
            r.count = pulse_len(c);
         end
         PH_HI_LOW, PH_LO_LOW: begin
            r.en    = 1'b0;
            r.count = pulse_len(c);
         end
         PH_WAIT: begin
            r.en    = 1'b0;
            r.count = {4'd0, c.byte_wait_ticks} + (s.extra ? CLEAR_EXTRA : 8'd0);
         end
         default: begin
            r.phase = PH_IDLE;
            r.en    = 1'b0;
         end
      endcase
      enter = r;
   endfunction

   // Pick the stage that follows s, loading the next init command where due.
   function automatic seq_state_type follow(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      case (s.phase)
         PH_POWER: begin
            r.phase   = PH_NIB_EN;
            r.nib_idx = 2'd0;
         end
         PH_NIB_EN:  r.phase = PH_NIB_LOW;
         PH_NIB_LOW: r.phase = PH_NIB_GAP;
         PH_NIB_GAP: begin
            if (s.nib_idx == NIB_LAST) begin
               r.phase    = PH_HI_EN;
               r.cmd_idx  = CMD_FUNCTION;
               r.byte_val = init_code(CMD_FUNCTION, c);
               r.rs       = 1'b0;
               r.extra    = 1'b0;
            end else begin
               r.phase   = PH_NIB_EN;
               r.nib_idx = s.nib_idx + 2'd1;
            end
         end
         PH_HI_EN:  r.phase = PH_HI_LOW;
         PH_HI_LOW: r.phase = PH_LO_EN;
         PH_LO_EN:  r.phase = PH_LO_LOW;
         PH_LO_LOW: r.phase = PH_WAIT;
         PH_WAIT: begin
            if (s.cmd_idx < CMD_LAST_INIT) begin
               r.phase    = PH_HI_EN;
               r.cmd_idx  = s.cmd_idx + 3'd1;
               r.byte_val = init_code(s.cmd_idx + 3'd1, c);
               r.rs       = 1'b0;
               r.extra    = (s.cmd_idx + 3'd1 == CMD_LAST_INIT);
            end else begin
               r.phase = PH_IDLE;
            end
         end
         default: r.phase = PH_IDLE;
      endcase
      follow = r;
   endfunction

   // Enter a stage; only the power-up wait and the byte wait can be empty, and
   // what follows either of them is never empty, so one skip is enough.
   function automatic seq_state_type run(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = enter(s, c);
      if (r.phase != PH_IDLE && r.count == 8'd0) begin
         r = enter(follow(r, c), c);
      end
      run = r;
   endfunction

   assign busy       = (st_ff.phase != PH_IDLE);
   assign is_request = (kind inside {KIND_COMMAND, KIND_DATA, KIND_CURSOR,
                                     KIND_CLEAR, KIND_INIT});

   // Next state.
   always_comb begin
      logic [6:0] base;
      st_in = st_ff;
      base  = line ? cfg.second_line_base : 7'd0;
      if (kind == KIND_TICK) begin
         if (busy) begin
            if (st_ff.count != 8'd0) begin
               st_in.count = st_ff.count - 8'd1;
            end
            if (st_in.count == 8'd0) begin
               st_in = run(follow(st_in, cfg), cfg);
            end
         end
      end else if (is_request && !busy) begin
         st_in.cmd_idx = CMD_STANDALONE;
         st_in.phase   = PH_HI_EN;
         st_in.rs      = 1'b0;
         st_in.extra   = 1'b0;
         case (kind)
            KIND_COMMAND: st_in.byte_val = byte_value;
            KIND_DATA: begin
               st_in.byte_val = byte_value;
               st_in.rs       = 1'b1;
            end
            KIND_CURSOR: st_in.byte_val = CURSOR_FLAG | {1'b0, base + {1'b0, column}};
            KIND_CLEAR: begin
               st_in.byte_val = CLEAR_CODE;
               st_in.extra    = 1'b1;
            end
            KIND_INIT: st_in.phase = PH_POWER;
            default: st_in.phase = PH_IDLE;
         endcase
         st_in = run(st_in, cfg);
      end
   end

   // Result of this word: the pin levels after the step.
   always_comb begin
      rsp.reg_select = st_in.rs;
      rsp.bus_nibble = st_in.nib;
      rsp.enable_pin = st_in.en;
      rsp.busy_res   = (st_in.phase != PH_IDLE);
      rsp.rejected   = is_request && busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase: PH_IDLE, default: '0};
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   // A running sequence never sits on an empty stage.
   assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase != PH_IDLE) |-> (st_ff.count != 8'd0))
      else $error("sequencer busy with an empty countdown");

   // Enable is only high in the strobe stages.
   assert property (@(posedge clock) disable iff (reset)
      st_ff.en |-> (st_ff.phase == PH_NIB_EN || st_ff.phase == PH_HI_EN
                    || st_ff.phase == PH_LO_EN))
      else $error("enable high outside a strobe stage");

   // RS is only high for a data byte, never during init.
   assert property (@(posedge clock) disable iff (reset)
      (st_ff.rs && st_ff.phase != PH_IDLE) |-> (st_ff.cmd_idx == CMD_STANDALONE))
      else $error("RS high during the init sequence");

endmodule

FILE: rtl/char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer
// Turns ticks and requests into RS, D7..D4 and enable levels for a character
// LCD on a 4-bit bus, one result word for every input word.
// ----------------------------------------------------------------------------
// Order: a word accepted is held in the input register, and its result is
// registered in the result register when the sequencer steps it, then offered.
// Throughput: one word per cycle while results are taken; while a result
// waits, one more word can enter the input register, then requests stall.
// Reset: synchronous, active high; the sequencer returns to idle with all pin
// levels low and the configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_kind,
   input  logic [7:0]                        req_byte_value,
   input  logic                              req_line,
   input  logic [5:0]                        req_column,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_reg_select,
   output logic [3:0]                        rsp_bus_nibble,
   output logic                              rsp_enable_pin,
   output logic                              rsp_busy_res,
   output logic                              rsp_rejected,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lcdns_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lcdns_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lcdns_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import lcdns_pkg::*;

   // Input register: the word waiting to be stepped through the sequencer.
   logic       in_valid_ff;
   logic [2:0] kind_ff;
   logic [7:0] byte_value_ff;
   logic       line_ff;
   logic [5:0] column_ff;

   // Result register: the pin levels after the stepped word.
   logic       out_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;

   cfg_type    cfg;
   logic       advance;
   logic       req_take;

   // The sequencer steps a word whenever the result register is free or is
   // being emptied in the same cycle. The input register refills as it drains,
   // so while results are taken, back-to-back words flow at one per cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff       <= req_kind;
         byte_value_ff <= req_byte_value;
         line_ff       <= req_line;
         column_ff     <= req_column;
      end
   end

   lcdns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The sequencer state only moves on an advancing word, so the step and the
   // result register stay in lock-step whatever the stalls on either side.
   lcdns_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .kind       (kind_ff),
      .byte_value (byte_value_ff),
      .line       (line_ff),
      .column     (column_ff),
      .cfg        (cfg),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_reg_select = rsp_ff.reg_select;
   assign rsp_bus_nibble = rsp_ff.bus_nibble;
   assign rsp_enable_pin = rsp_ff.enable_pin;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_rejected   = rsp_ff.rejected;

   // A dropped request leaves the running sequence untouched, so it still
   // reports busy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> rsp_busy_res)
      else $error("rejected request reported while idle");

   // Enable can only be high while a sequence is running.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_enable_pin) |-> rsp_busy_res)
      else $error("enable strobe reported while idle");

   // A result word that is not taken stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("waiting result word changed or was withdrawn");

endmodule
